FILE: rtl/core/scr_pkg.sv
// Package: shared constants, types and helpers for the SHiP/RRIP replacement block.
`default_nettype none
package scr_pkg;
    localparam int NUM_SETS_DEF = 1024;
    localparam int NUM_WAYS_DEF = 16;
    localparam int SIGNATURE_BITS_DEF = 14;
    localparam int CMD_W = 2;
    localparam int SET_W = 10;
    localparam int WAY_W = 4;
    localparam int PC_W = 64;
    localparam int TAG_W = 14;
    localparam int VAL_W = 4;
    localparam int PC_SHIFT = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [1:0] {
        CMD_HIT = 2'd0, CMD_FILL = 2'd1, CMD_INVAL = 2'd2, CMD_VICTIM = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_SIG_MODE = 2'd0, CFG_CNT_BITS = 2'd1, CFG_RRPV_BITS = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_SCAN, ST_CNT_RD, ST_CNT_WR, ST_OUT
    } state_t;

    // saturating maximum for a configured width (0 acts as 1, above 4 as 4)
    function automatic logic [VAL_W-1:0] width_max(input logic [2:0] bits);
        logic [VAL_W-1:0] m;
        case (bits)
            3'd0, 3'd1: m = 4'd1;
            3'd2: m = 4'd3;
            3'd3: m = 4'd7;
            default: m = 4'd15;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/ship_cache_replacement_top.sv
// Top level: SHiP-over-RRIP replacement state with a set memory and a counter memory.
//
// One word is in work at a time and runs through a sequence of states. Hit, fill and
// invalidate pass through ST_READ, ST_CNT_RD, ST_CNT_WR and ST_OUT after the word is
// accepted, and the next word can be accepted once ST_OUT is left. Select victim reads the
// whole set row and scans it one way per cycle, stopping at the first invalid way. If no
// way is invalid, the row is then aged and written back and the victim's counter is
// trained before the result is given. The reuse counter table is a separate memory with
// a registered read. A result waits in the output register while m_tready is low. The
// next word is processed meanwhile and stalls only when its own result is ready. After
// reset a clearing pass over max(NUM_SETS, 2^SIGNATURE_BITS) addresses zeroes the
// valid/RRPV/reused fields and the counters; no word is accepted meanwhile.
`default_nettype none
module ship_cache_replacement_top #(
    parameter int NUM_SETS       = scr_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS       = scr_pkg::NUM_WAYS_DEF,
    parameter int SIGNATURE_BITS = scr_pkg::SIGNATURE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[1:0], set_index[11:2], way[15:12], pc[79:16], tag[93:80], zero pad
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // victim_way[3:0], victim_was_invalid[4], command_done[5], zero pad
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [scr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scr_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int SA_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WI_W   = $clog2(NUM_WAYS);
    localparam int SIGN   = 1 << SIGNATURE_BITS;
    localparam int LINE_W = 6 + SIGNATURE_BITS; // valid, rrpv[4], reused, sig
    localparam int ROW_W  = LINE_W * NUM_WAYS;
    localparam int CLR_N  = (NUM_SETS > SIGN) ? NUM_SETS : SIGN;
    localparam int CLR_W  = $clog2(CLR_N) + 1;
    localparam int SCAN_W = $clog2(NUM_WAYS + 1);
    localparam int PCX_W  = scr_pkg::PC_W + 4 * SIGNATURE_BITS;
    // reciprocal for wrapping a set index into NUM_SETS
    localparam int SET_SH = scr_pkg::SET_W + $clog2(NUM_SETS);
    localparam int SET_RM = ((1 << SET_SH) + NUM_SETS - 1) / NUM_SETS;

    // configuration
    logic       sig_mode_reg;
    logic [2:0] cnt_bits_reg, rrpv_bits_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_mode_reg  <= 1'b1;
            cnt_bits_reg  <= 3'd2;
            rrpv_bits_reg <= 3'd2;
        end else if (cfg_we) begin
            case (scr_pkg::cfg_idx_t'(cfg_index))
                scr_pkg::CFG_SIG_MODE:  sig_mode_reg  <= cfg_data[0];
                scr_pkg::CFG_CNT_BITS:  cnt_bits_reg  <= cfg_data;
                scr_pkg::CFG_RRPV_BITS: rrpv_bits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input fields
    logic [1:0]  in_cmd;
    logic [9:0]  in_set;
    logic [3:0]  in_way;
    logic [63:0] in_pc;
    logic [13:0] in_tag;
    assign in_cmd = s_tdata[1:0];
    assign in_set = s_tdata[11:2];
    assign in_way = s_tdata[15:12];
    assign in_pc  = s_tdata[79:16];
    assign in_tag = s_tdata[93:80];

    // set index modulo NUM_SETS by reciprocal multiplication
    logic [31:0]     set_prod, set_quot, set_rem;
    logic [SA_W-1:0] set_wrap;
    always_comb begin
        set_prod = 32'(in_set) * 32'(SET_RM);
        set_quot = set_prod >> SET_SH;
        set_rem  = 32'(in_set) - set_quot * 32'(NUM_SETS);
    end
    assign set_wrap = set_rem[SA_W-1:0];

    // pc hash: bit i is parity of nibble i of pc>>8
    logic [PCX_W-1:0]          pc_ext;
    logic [SIGNATURE_BITS-1:0] hash_sig;
    assign pc_ext = PCX_W'(in_pc);
    always_comb begin
        for (int i = 0; i < SIGNATURE_BITS; i++) begin
            hash_sig[i] = ^pc_ext[scr_pkg::PC_SHIFT + 4*i +: 4];
        end
    end

    // latched item
    logic [1:0]                cmd_reg;
    logic [SA_W-1:0]           set_reg;
    logic [3:0]                way_reg;
    logic [SIGNATURE_BITS-1:0] sig_reg;
    logic                      have_sig_reg;
    logic [3:0]                cmax_reg, rmax_reg;

    scr_pkg::state_t state_reg, state_next;
    logic [CLR_W-1:0]  clr_reg;
    logic              clearing;
    logic [SCAN_W-1:0] scan_reg;
    logic [WI_W-1:0]   best_reg;
    logic [3:0]        best_r_reg;
    logic              found_inv_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              out_valid_reg;
    logic [3:0]        out_way_reg;
    logic              out_inv_reg;
    logic [3:0]        res_way_reg;
    logic              res_inv_reg;
    logic [SIGNATURE_BITS-1:0] csig_reg;
    logic              cinc_reg;

    // memories
    logic              row_we;
    logic [SA_W-1:0]   row_waddr, row_raddr;
    logic [ROW_W-1:0]  row_wdata, row_rdata;
    logic              cnt_we;
    logic [SIGNATURE_BITS-1:0] cnt_waddr, cnt_raddr;
    logic [3:0]        cnt_wdata, cnt_rdata;

    // the row read starts at the accepting edge so it is ready in ST_READ
    assign row_raddr = (state_reg == scr_pkg::ST_IDLE) ? set_wrap : set_reg;

    scr_ram #(.WIDTH(ROW_W), .DEPTH(1 << SA_W)) u_row_ram (
        .aclk(aclk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata));
    scr_ram #(.WIDTH(4), .DEPTH(SIGN)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata));

    assign clearing = (clr_reg < CLR_W'(CLR_N));
    assign s_tready = !clearing && state_reg == scr_pkg::ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, 1'b1, out_inv_reg, out_way_reg};

    // current way of the scan and of the addressed line
    logic [WI_W-1:0]   scan_idx, way_idx;
    logic [LINE_W-1:0] scan_line, tgt_line, victim_line;
    logic              way_ok;
    assign scan_idx    = scan_reg[WI_W-1:0];
    assign way_idx     = WI_W'(way_reg);
    assign scan_line   = row_reg[scan_idx*LINE_W +: LINE_W];
    assign way_ok      = (32'(way_reg) < NUM_WAYS);
    assign tgt_line    = row_reg[way_idx*LINE_W +: LINE_W];
    assign victim_line = row_reg[best_reg*LINE_W +: LINE_W];

    // line field order: [0] valid, [4:1] rrpv, [5] reused, [LINE_W-1:6] sig
    logic [ROW_W-1:0] aged_row, mod_row;
    logic [LINE_W-1:0] new_line;
    always_comb begin
        logic [3:0] diff;
        logic [4:0] r;
        diff = (best_r_reg < rmax_reg) ? rmax_reg - best_r_reg : 4'd0;
        aged_row = row_reg;
        for (int w = 0; w < NUM_WAYS; w++) begin
            r = {1'b0, row_reg[w*LINE_W+1 +: 4]} + {1'b0, diff};
            if (diff != 4'd0) begin
                aged_row[w*LINE_W+1 +: 4] = (r > {1'b0, rmax_reg}) ? rmax_reg : r[3:0];
            end
        end
        new_line = tgt_line;
        case (scr_pkg::cmd_t'(cmd_reg))
            scr_pkg::CMD_HIT: begin
                new_line[5] = 1'b1;
                if (tgt_line[4:1] != 4'd0) new_line[4:1] = tgt_line[4:1] - 4'd1;
            end
            scr_pkg::CMD_FILL: begin
                new_line[5]   = 1'b0;
                new_line[4:1] = rmax_reg;
                if (have_sig_reg) begin
                    new_line[LINE_W-1:6] = sig_reg;
                    if (cnt_rdata != 4'd0) new_line[4:1] = rmax_reg - 4'd1;
                    new_line[0] = 1'b1;
                end
            end
            default: new_line[0] = 1'b0;
        endcase
        mod_row = row_reg;
        mod_row[way_idx*LINE_W +: LINE_W] = new_line;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        row_we = 1'b0; row_waddr = set_reg; row_wdata = mod_row;
        cnt_we = 1'b0; cnt_waddr = csig_reg; cnt_wdata = cnt_rdata;
        cnt_raddr = sig_reg;
        if (clearing) begin
            row_we    = 1'b1;
            row_waddr = clr_reg[SA_W-1:0];
            row_wdata = '0;
            cnt_we    = 1'b1;
            cnt_waddr = clr_reg[SIGNATURE_BITS-1:0];
            cnt_wdata = 4'd0;
        end else begin
            case (state_reg)
                scr_pkg::ST_IDLE:
                    if (s_tvalid && s_tready) state_next = scr_pkg::ST_READ;
                scr_pkg::ST_READ: state_next = (cmd_reg == scr_pkg::CMD_VICTIM)
                                               ? scr_pkg::ST_SCAN : scr_pkg::ST_CNT_RD;
                scr_pkg::ST_SCAN: begin
                    cnt_raddr = victim_line[LINE_W-1:6];
                    if (found_inv_reg || scan_reg == SCAN_W'(NUM_WAYS)) begin
                        if (!found_inv_reg) row_wdata = aged_row;
                        row_we = !found_inv_reg;
                        state_next = found_inv_reg ? scr_pkg::ST_OUT : scr_pkg::ST_CNT_WR;
                    end
                end
                scr_pkg::ST_CNT_RD: begin
                    row_we = way_ok;
                    state_next = scr_pkg::ST_CNT_WR;
                end
                scr_pkg::ST_CNT_WR: begin
                    cnt_we = cinc_reg ? (cnt_rdata < cmax_reg) : (cnt_rdata != 4'd0);
                    cnt_wdata = cinc_reg ? cnt_rdata + 4'd1 : cnt_rdata - 4'd1;
                    state_next = scr_pkg::ST_OUT;
                end
                // wait while the previous result still sits in the output register
                scr_pkg::ST_OUT: state_next = (out_valid_reg && !m_tready)
                                              ? scr_pkg::ST_OUT : scr_pkg::ST_IDLE;
                default: state_next = scr_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= scr_pkg::ST_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cinc_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + CLR_W'(1);
            if (m_tvalid && m_tready && state_reg != scr_pkg::ST_OUT) out_valid_reg <= 1'b0;
            case (state_reg)
                scr_pkg::ST_IDLE: if (s_tvalid && s_tready) begin
                    cmd_reg <= in_cmd;
                    set_reg <= set_wrap;
                    way_reg <= in_way;
                    sig_reg <= sig_mode_reg ? hash_sig : SIGNATURE_BITS'(in_tag);
                    have_sig_reg  <= !(sig_mode_reg && in_pc == 64'd0);
                    cmax_reg      <= scr_pkg::width_max(cnt_bits_reg);
                    rmax_reg      <= scr_pkg::width_max(rrpv_bits_reg);
                    scan_reg      <= '0;
                    best_reg      <= '0;
                    found_inv_reg <= 1'b0;
                end
                scr_pkg::ST_READ: begin
                    row_reg    <= row_rdata;
                    best_r_reg <= row_rdata[4:1];
                end
                scr_pkg::ST_SCAN: begin
                    if (found_inv_reg || scan_reg == SCAN_W'(NUM_WAYS)) begin
                        csig_reg <= victim_line[LINE_W-1:6];
                        // a reused victim skips training: an increment capped at zero
                        cinc_reg <= victim_line[5];
                        res_way_reg <= 4'(best_reg);
                        res_inv_reg <= found_inv_reg;
                        if (!found_inv_reg && victim_line[5]) cmax_reg <= 4'd0;
                    end else begin
                        scan_reg <= scan_reg + SCAN_W'(1);
                        if (!scan_line[0]) begin
                            found_inv_reg <= 1'b1;
                            best_reg <= scan_idx;
                        end else if (scan_line[4:1] > best_r_reg) begin
                            best_reg <= scan_idx;
                            best_r_reg <= scan_line[4:1];
                        end
                    end
                end
                scr_pkg::ST_CNT_RD: begin
                    csig_reg    <= sig_reg;
                    cinc_reg    <= 1'b1;
                    if (!(cmd_reg == scr_pkg::CMD_HIT && way_ok && have_sig_reg))
                        cmax_reg <= 4'd0;
                    res_way_reg <= 4'd0;
                    res_inv_reg <= 1'b0;
                end
                // load the output register once it is free or being emptied
                scr_pkg::ST_OUT: if (!out_valid_reg || m_tready) begin
                    out_valid_reg <= 1'b1;
                    out_way_reg   <= res_way_reg;
                    out_inv_reg   <= res_inv_reg;
                end
                default: ;
            endcase
        end
    end

    // checks
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready) else $error("accept during clear");
    a_out_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == scr_pkg::ST_OUT)
        else $error("result without sequence");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

FILE: rtl/core/scr_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
`default_nettype none
module scr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
